// ===== rtl/umss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umss_pkg
// Shared codes, defaults and controller/datapath interface types for the
// valley-minimum search scheduler.
// ----------------------------------------------------------------------------
package umss_pkg;

    localparam int MAX_SLOTS_DEFAULT  = 16;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int COUNT_RESET        = 5;

    // slot status codes
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    // result instruction codes
    localparam logic [1:0] INS_TRY  = 2'd0;
    localparam logic [1:0] INS_WAIT = 2'd1;
    localparam logic [1:0] INS_END  = 2'd2;

    // input operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    // scan pointer operations
    localparam int PTR_W = 3;
    localparam logic [PTR_W-1:0] PTR_HOLD = 3'd0;
    localparam logic [PTR_W-1:0] PTR_ZERO = 3'd1;
    localparam logic [PTR_W-1:0] PTR_LAST = 3'd2;
    localparam logic [PTR_W-1:0] PTR_INC  = 3'd3;
    localparam logic [PTR_W-1:0] PTR_DEC  = 3'd4;

    typedef struct packed {
        logic             report_write;
        logic             req_start;
        logic [PTR_W-1:0] ptr_op;
        logic             take_l;
        logic             take_r;
        logic             force_left;
        logic             force_right;
        logic             emit_decide;
        logic             emit_end;
    } cmd_t;

    typedef struct packed {
        logic [1:0] st_cur;
        logic       ptr_zero;
        logic       ptr_last;
        logic       greater;
        logic       equal;
        logic       all_handled;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/umss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umss_ctrl
// Sequencer: accepts beats, walks the left and right scans one slot per
// cycle and tells the datapath when to emit a result.
// ----------------------------------------------------------------------------
module umss_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           operation,
    input  wire umss_pkg::stat_t stat,
    output umss_pkg::cmd_t      cmd,
    output logic                item_stall
);
    import umss_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LSCAN  = 3'd1;
    localparam logic [2:0] S_CHKL   = 3'd2;
    localparam logic [2:0] S_RSCAN  = 3'd3;
    localparam logic [2:0] S_CHKR   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_END    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (operation == OP_REPORT)
                    begin
                        cmd.report_write = 1'b1;
                    end
                    else if (stat.all_handled)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        cmd.req_start = 1'b1;
                        cmd.ptr_op    = PTR_ZERO;
                        state_next    = S_LSCAN;
                    end
                end
            end
            S_LSCAN:
            begin
                if (stat.st_cur == ST_UNKNOWN || stat.st_cur == ST_PENDING)
                begin
                    cmd.take_l = 1'b1;
                    cmd.ptr_op = PTR_LAST;
                    state_next = S_RSCAN;
                end
                else if (!stat.ptr_zero && stat.greater)
                begin
                    // left side turned upward: check the far end first
                    cmd.ptr_op = PTR_LAST;
                    state_next = S_CHKL;
                end
                else
                begin
                    cmd.force_left = !stat.ptr_zero && stat.equal;
                    if (stat.ptr_last)
                    begin
                        cmd.ptr_op = PTR_LAST;
                        state_next = S_RSCAN;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                    end
                end
            end
            S_CHKL:
            begin
                // pointer now sits on the last slot; right scan starts there
                state_next = (stat.st_cur != ST_UNKNOWN) ? S_END : S_RSCAN;
            end
            S_RSCAN:
            begin
                if (stat.st_cur == ST_UNKNOWN || stat.st_cur == ST_PENDING)
                begin
                    cmd.take_r = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (!stat.ptr_last && stat.greater)
                begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = S_CHKR;
                end
                else
                begin
                    cmd.force_right = !stat.ptr_last && stat.equal;
                    if (stat.ptr_zero)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_DEC;
                    end
                end
            end
            S_CHKR:
            begin
                state_next = (stat.st_cur != ST_UNKNOWN) ? S_END : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_decide = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_END:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/umss_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umss_datapath
// Slot status flops, value memory, scan pointer and comparator, handout
// decision and the result register.
// ----------------------------------------------------------------------------
module umss_datapath #(
    parameter int MAX_SLOTS  = umss_pkg::MAX_SLOTS_DEFAULT,
    parameter int VALUE_BITS = umss_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write_enable,
    input  wire logic [4:0]      cfg_write_data,
    input  wire logic [3:0]      slot_index,
    input  wire logic [31:0]     measured_value,
    input  wire umss_pkg::cmd_t  cmd,
    output umss_pkg::stat_t      stat,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output logic [1:0]           instruction,
    output logic [3:0]           try_slot
);
    import umss_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] COUNT_INIT =
        CW'((COUNT_RESET < MAX_SLOTS) ? COUNT_RESET : MAX_SLOTS);

    logic [1:0]            status_reg [MAX_SLOTS];
    logic [VALUE_BITS-1:0] value_mem  [MAX_SLOTS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] prev_reg;

    logic [CW-1:0] count_reg,   count_next;
    logic [IW-1:0] last_reg,    last_next;
    logic [CW-1:0] handled_reg, handled_next;
    logic [IW-1:0] ptr_reg,     ptr_next;
    logic          toggle_reg;
    logic          left_first_reg;
    logic [IW-1:0] lnext_reg, rnext_reg;
    logic          lvalid_reg, rvalid_reg, ldo_reg, rdo_reg;

    logic          result_valid_reg;
    logic [1:0]    instruction_reg;
    logic [3:0]    try_slot_reg;

    logic          report_ok;
    logic [IW-1:0] wr_idx;
    logic [1:0]    st_cur;

    // handout decision
    logic [IW-1:0] a_idx, b_idx, sel_idx;
    logic          a_do, b_do, a_val, b_val;
    logic          hand, sel_do;

    assign st_cur    = status_reg[ptr_reg];
    assign report_ok = cmd.report_write && (32'(slot_index) < 32'(count_reg));
    assign wr_idx    = IW'(slot_index);

    assign stat.st_cur      = st_cur;
    assign stat.ptr_zero    = (ptr_reg == '0);
    assign stat.ptr_last    = (ptr_reg == last_reg);
    assign stat.greater     = (rd_data_reg > prev_reg);
    assign stat.equal       = (rd_data_reg == prev_reg);
    assign stat.all_handled = (handled_reg == count_reg);
    assign stat.out_free    = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign instruction  = instruction_reg;
    assign try_slot     = try_slot_reg;

    always_comb
    begin
        a_idx = left_first_reg ? lnext_reg  : rnext_reg;
        b_idx = left_first_reg ? rnext_reg  : lnext_reg;
        a_do  = left_first_reg ? ldo_reg    : rdo_reg;
        b_do  = left_first_reg ? rdo_reg    : ldo_reg;
        a_val = left_first_reg ? lvalid_reg : rvalid_reg;
        b_val = left_first_reg ? rvalid_reg : lvalid_reg;
        hand    = 1'b1;
        sel_idx = a_idx;
        sel_do  = 1'b0;
        if (a_do)
        begin
            sel_do = 1'b1;
        end
        else if (b_do)
        begin
            sel_idx = b_idx;
            sel_do  = 1'b1;
        end
        else if (handled_reg > CW'(2) && a_val)
        begin
            sel_idx = a_idx;
        end
        else if (handled_reg > CW'(3) && b_val)
        begin
            sel_idx = b_idx;
        end
        else
        begin
            hand = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write_data == 5'd0)
        begin
            count_next = CW'(1);
        end
        else if (32'(cfg_write_data) > 32'(MAX_SLOTS))
        begin
            count_next = CW'(MAX_SLOTS);
        end
        else
        begin
            count_next = CW'(cfg_write_data);
        end
        last_next = IW'(count_next - CW'(1));
    end

    always_comb
    begin
        handled_next = handled_reg;
        if (cfg_write_enable)
        begin
            handled_next = '0;
        end
        else if (report_ok && status_reg[wr_idx] == ST_UNKNOWN)
        begin
            handled_next = handled_reg + CW'(1);
        end
        else if (cmd.emit_decide && hand && sel_do)
        begin
            handled_next = handled_reg + CW'(1);
        end
    end

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_LAST: ptr_next = last_reg;
            PTR_INC:  ptr_next = ptr_reg + IW'(1);
            PTR_DEC:  ptr_next = ptr_reg - IW'(1);
            default:  ptr_next = ptr_reg;
        endcase
        if (cfg_write_enable)
        begin
            ptr_next = '0;
        end
    end

    // value memory: written by reports, read one slot per cycle at the
    // pointer's next value so rd_data_reg tracks the current slot
    always_ff @(posedge clk)
    begin
        if (report_ok)
        begin
            value_mem[wr_idx] <= VALUE_BITS'(measured_value);
        end
        rd_data_reg <= value_mem[ptr_next];
        if (cmd.ptr_op == PTR_INC || cmd.ptr_op == PTR_DEC)
        begin
            prev_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                status_reg[i] <= ST_UNKNOWN;
            end
        end
        else if (cfg_write_enable)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                status_reg[i] <= ST_UNKNOWN;
            end
        end
        else if (report_ok)
        begin
            status_reg[wr_idx] <= ST_DONE;
        end
        else if (cmd.emit_decide && hand)
        begin
            status_reg[sel_idx] <= ST_PENDING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= COUNT_INIT;
            last_reg         <= IW'(COUNT_INIT - CW'(1));
            handled_reg      <= '0;
            ptr_reg          <= '0;
            toggle_reg       <= 1'b0;
            left_first_reg   <= 1'b0;
            lvalid_reg       <= 1'b0;
            rvalid_reg       <= 1'b0;
            ldo_reg          <= 1'b0;
            rdo_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                count_reg <= count_next;
                last_reg  <= last_next;
            end
            handled_reg <= handled_next;
            ptr_reg     <= ptr_next;

            if (cmd.req_start)
            begin
                toggle_reg     <= !toggle_reg;
                left_first_reg <= !toggle_reg;
                lvalid_reg     <= 1'b0;
                rvalid_reg     <= 1'b0;
                ldo_reg        <= 1'b0;
                rdo_reg        <= 1'b0;
            end
            if (cmd.force_left)
            begin
                left_first_reg <= 1'b1;
            end
            if (cmd.force_right)
            begin
                left_first_reg <= 1'b0;
            end
            if (cmd.take_l)
            begin
                lvalid_reg <= 1'b1;
                ldo_reg    <= (st_cur == ST_UNKNOWN);
            end
            if (cmd.take_r)
            begin
                rvalid_reg <= 1'b1;
                rdo_reg    <= (st_cur == ST_UNKNOWN);
            end

            if (cmd.emit_decide || cmd.emit_end)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_l)
        begin
            lnext_reg <= ptr_reg;
        end
        if (cmd.take_r)
        begin
            rnext_reg <= ptr_reg;
        end
        if (cmd.emit_end)
        begin
            instruction_reg <= INS_END;
            try_slot_reg    <= 4'd0;
        end
        else if (cmd.emit_decide)
        begin
            instruction_reg <= hand ? INS_TRY : INS_WAIT;
            try_slot_reg    <= hand ? 4'(sel_idx) : 4'd0;
        end
    end

    a_handled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        handled_reg <= count_reg)
        else $error("handled count exceeds slot count");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= last_reg)
        else $error("scan pointer beyond last slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_decide || cmd.emit_end) |-> stat.out_free)
        else $error("result emitted over a stalled beat");

    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        (report_ok && !cfg_write_enable) |=> status_reg[$past(wr_idx)] == ST_DONE)
        else $error("reported slot not marked done");

endmodule
`default_nettype wire

// ===== rtl/unimodal_minimum_search_scheduler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unimodal_minimum_search_scheduler_core
// Valley-minimum trial scheduler: hands out slots to try, waits or ends.
// ----------------------------------------------------------------------------
// A report beat (operation 1) gives no result. A request beat (operation 0)
// gives exactly one result. When no slot is unknown it skips the scans and
// ends. Otherwise the beat is taken, the scans visit their slots, a scan
// that turns upward is followed by an end check, and the result is decided.
// The scans walk the value memory through its single read port, one slot per
// cycle. The left scan stops at the first slot not yet done and the right
// scan at the last one, so together they visit at most slot_count + 1 slots.
// A stalled result register adds its stall cycles before the decision. Only
// one beat is in work at a time; a finished result sits in the output
// register while the next beat is taken. Writing slot_count (zero acts as one,
// anything above MAX_SLOTS as MAX_SLOTS) clears every slot to unknown in that
// cycle.
// ----------------------------------------------------------------------------
module unimodal_minimum_search_scheduler_core #(
    parameter int MAX_SLOTS  = umss_pkg::MAX_SLOTS_DEFAULT,
    parameter int VALUE_BITS = umss_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [4:0]  cfg_write_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        operation,
    input  wire logic [3:0]  slot_index,
    input  wire logic [31:0] measured_value,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       instruction,
    output logic [3:0]       try_slot
);
    import umss_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    umss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (operation),
        .stat       (stat),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    umss_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .slot_index       (slot_index),
        .measured_value   (measured_value),
        .cmd              (cmd),
        .stat             (stat),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction      (instruction),
        .try_slot         (try_slot)
    );

endmodule
`default_nettype wire

// ===== test/unimodal_minimum_search_scheduler_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unimodal_minimum_search_scheduler_checker
// Watches the config port and both channels of the search scheduler, keeps
// its own copy of the slot table, works out the answer owed to every request
// beat and compares each answer beat against the oldest one still owed.
// ----------------------------------------------------------------------------
module unimodal_minimum_search_scheduler_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [4:0]  cfg_write_data,
    input  wire logic        item_valid,
    input  wire logic        item_stall,
    input  wire logic        operation,
    input  wire logic [3:0]  slot_index,
    input  wire logic [31:0] measured_value,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic [1:0]  instruction,
    input  wire logic [3:0]  try_slot,
    output int               mismatch_count,
    output int               answers_owed
);
    import umss_pkg::*;

    localparam int SLOTS = MAX_SLOTS_DEFAULT;

    typedef struct packed {
        logic [1:0] instruction;
        logic [3:0] try_slot;
    } answer_t;

    logic [1:0]  slot_state [SLOTS];
    logic [31:0] slot_cost [SLOTS];
    logic        side_flag;
    int          active_slots;
    answer_t     owed_answers [$];

    function automatic void clear_table();
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_state[s] = ST_UNKNOWN;
            slot_cost[s]  = '0;
        end
    endfunction

    function automatic void apply_slot_count(input logic [4:0] value);
        int n;
        n = value;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        active_slots = n;
        clear_table();
    endfunction

    function automatic answer_t plain_answer(input logic [1:0] code);
        answer_t a;
        a.instruction = code;
        a.try_slot    = '0;
        return a;
    endfunction

    function automatic answer_t assign_trial(input int s);
        answer_t a;
        slot_state[s] = ST_PENDING;
        a.instruction = INS_TRY;
        a.try_slot    = 4'(s);
        return a;
    endfunction

    // Answer to one request beat; updates the slot table and the side flag.
    function automatic answer_t next_trial();
        int last;
        int handled;
        int c;
        int lcand;
        int rcand;
        int swap_slot;
        bit lfresh;
        bit rfresh;
        bit swap_flag;
        bit lead_left;
        last    = active_slots - 1;
        lcand   = -1;
        rcand   = -1;
        lfresh  = 1'b0;
        rfresh  = 1'b0;
        handled = 0;
        for (c = 0; c < active_slots; c++)
            if (slot_state[c] != ST_UNKNOWN)
                handled++;
        if (handled == active_slots)
            return plain_answer(INS_END);

        side_flag = ~side_flag;
        lead_left = side_flag;

        // walk down the left slope
        for (c = 0; c <= last; c++)
        begin
            if (slot_state[c] == ST_UNKNOWN)
            begin
                lcand  = c;
                lfresh = 1'b1;
                break;
            end
            if (slot_state[c] == ST_PENDING)
            begin
                lcand = c;
                break;
            end
            if (c == 0)
                continue;
            if (slot_cost[c] > slot_cost[c-1])
            begin
                if (slot_state[last] != ST_UNKNOWN)
                    return plain_answer(INS_END);
                break;
            end
            if (slot_cost[c] == slot_cost[c-1])
                lead_left = 1'b1;
        end

        // and the right one, mirrored
        for (c = last; c >= 0; c--)
        begin
            if (slot_state[c] == ST_UNKNOWN)
            begin
                rcand  = c;
                rfresh = 1'b1;
                break;
            end
            if (slot_state[c] == ST_PENDING)
            begin
                rcand = c;
                break;
            end
            if (c == last)
                continue;
            if (slot_cost[c] > slot_cost[c+1])
            begin
                if (slot_state[0] != ST_UNKNOWN)
                    return plain_answer(INS_END);
                break;
            end
            if (slot_cost[c] == slot_cost[c+1])
                lead_left = 1'b0;
        end

        if (!lead_left)
        begin
            swap_slot = lcand;
            lcand     = rcand;
            rcand     = swap_slot;
            swap_flag = lfresh;
            lfresh    = rfresh;
            rfresh    = swap_flag;
        end

        if (lfresh)
            return assign_trial(lcand);
        if (rfresh)
            return assign_trial(rcand);
        // nothing fresh: re-issue a pending slot once enough are settled
        if (handled > 2 && lcand >= 0)
            return assign_trial(lcand);
        if (handled > 3 && rcand >= 0)
            return assign_trial(rcand);
        return plain_answer(INS_WAIT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            clear_table();
            side_flag      = 1'b0;
            active_slots   = COUNT_RESET;
            owed_answers.delete();
            mismatch_count = 0;
            answers_owed   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("answer beat with none owed: instruction %0d, try_slot %0d",
                           instruction, try_slot);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (instruction !== want.instruction)
                    begin
                        $error("instruction: expected %0d, actual %0d",
                               want.instruction, instruction);
                        mismatch_count++;
                    end
                    if (try_slot !== want.try_slot)
                    begin
                        $error("try_slot: expected %0d, actual %0d",
                               want.try_slot, try_slot);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_write_enable)
                apply_slot_count(cfg_write_data);
            if (item_valid && !item_stall)
            begin
                if (operation == OP_REPORT)
                begin
                    if (slot_index < active_slots)
                    begin
                        slot_cost[slot_index]  = measured_value;
                        slot_state[slot_index] = ST_DONE;
                    end
                end
                else
                    owed_answers.push_back(next_trial());
            end
            answers_owed = owed_answers.size();
        end
    end

endmodule
`default_nettype wire

// ===== test/unimodal_minimum_search_scheduler_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unimodal_minimum_search_scheduler_core_test
// Drives the search scheduler with a short directed run and then with random
// search sessions over valley-shaped cost curves under varying slot counts,
// with random sender gaps and receiver stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module unimodal_minimum_search_scheduler_core_test;
    import umss_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_BEATS    = 330;
    localparam int SLOTS          = MAX_SLOTS_DEFAULT;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [4:0]  cfg_write_data   = '0;
    logic        item_valid       = 1'b0;
    logic        item_stall;
    logic        operation        = OP_REQUEST;
    logic [3:0]  slot_index       = '0;
    logic [31:0] measured_value   = '0;
    logic        result_valid;
    logic        result_stall     = 1'b0;
    logic [1:0]  instruction;
    logic [3:0]  try_slot;

    int          mismatch_count;
    int          answers_owed;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          beats_sent    = 0;
    int          slots_now     = COUNT_RESET;
    int          quiet_cycles;
    logic [31:0] valley [SLOTS];

    unimodal_minimum_search_scheduler_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .slot_index       (slot_index),
        .measured_value   (measured_value),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction      (instruction),
        .try_slot         (try_slot)
    );

    unimodal_minimum_search_scheduler_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .slot_index       (slot_index),
        .measured_value   (measured_value),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction      (instruction),
        .try_slot         (try_slot),
        .mismatch_count   (mismatch_count),
        .answers_owed     (answers_owed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // Entered and left at a falling edge; valid stays up between beats
    // unless a gap is drawn.
    task automatic send_beat(input logic op, input logic [3:0] idx,
                             input logic [31:0] cost);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid     <= 1'b1;
        operation      <= op;
        slot_index     <= idx;
        measured_value <= cost;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic request();
        send_beat(OP_REQUEST, 4'($urandom), $urandom);
    endtask

    task automatic report(input int idx, input logic [31:0] cost);
        send_beat(OP_REPORT, 4'(idx), cost);
    endtask

    // Hold off until every answer is back, then let a report finish too.
    task automatic settle();
        item_valid <= 1'b0;
        while (answers_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_slot_count(input logic [4:0] value);
        settle();
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        slots_now = (value == 0) ? 1 : (value > SLOTS) ? SLOTS : int'(value);
    endtask

    // One session: a random valley, mostly requests and reports that follow
    // it, some reports off the curve or past the slots in use.
    task automatic run_search(input int beats);
        int bottom;
        int pick;
        bottom = $urandom_range(0, slots_now - 1);
        valley[bottom] = $urandom >> $urandom_range(1, 31);
        for (int s = bottom - 1; s >= 0; s--)
            valley[s] = valley[s+1] + (($urandom_range(0, 3) == 0) ? 0 :
                                       $urandom_range(1, 1 << 16));
        for (int s = bottom + 1; s < slots_now; s++)
            valley[s] = valley[s-1] + (($urandom_range(0, 3) == 0) ? 0 :
                                       $urandom_range(1, 1 << 16));
        repeat (beats)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
                request();
            else if (pick < 90)
            begin
                pick = $urandom_range(0, slots_now - 1);
                report(pick, valley[pick]);
            end
            else if (pick < 95)
                report($urandom_range(0, SLOTS - 1), $urandom);
            else
                report($urandom_range(0, slots_now - 1), $urandom);
        end
    endtask

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                cfg_write_enable)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int target;
        int roll;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 68 : 0;
            stall_pct     = (phase == 0) ? 68 : (phase == 1) ? 33 : 0;

            if (phase == 0)
            begin
                // five slots out of reset: both ends, then a wait
                request();
                request();
                request();
                report(0, 32'hFFFF_FFFF);
                report(15, 32'h0);
                report(4, 32'hFFFF_FFF0);
                request();
                report(1, 32'h0);
                request();
                report(2, 32'h0);
                request();
                request();
                // zero acts as a single slot
                write_slot_count(5'd0);
                request();
                request();
                report(0, 32'h1234_5678);
                request();
                // two slots rising to the right end the search
                write_slot_count(5'd2);
                report(0, 32'd5);
                report(1, 32'd9);
                request();
                // above the slot limit clamps to sixteen
                write_slot_count(5'd31);
                request();
                request();
                report(15, 32'hAAAA_5555);
                request();
            end

            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    write_slot_count(5'($urandom_range(0, 31)));
                else if (roll < 75)
                    write_slot_count(5'($urandom_range(1, SLOTS)));
                else if (roll < 85)
                    settle();
                run_search($urandom_range(2 * slots_now, 3 * slots_now + 6));
            end
            write_slot_count((phase == 1) ? 5'd16 : 5'd1);
            run_search(3 * slots_now + 6);
        end

        settle();
        if (mismatch_count == 0 && answers_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

// ===== unimodal_minimum_search_scheduler_core.f =====
rtl/umss_pkg.sv
rtl/umss_ctrl.sv
rtl/umss_datapath.sv
rtl/unimodal_minimum_search_scheduler_core.sv
test/unimodal_minimum_search_scheduler_checker.sv
test/unimodal_minimum_search_scheduler_core_test.sv
